// ----- rtl/hash_table_quadratic_probe_assert.svh -----
// ----------------------------------------------------------------------------
// Hash table assertion macros
// Concurrent assertion wrappers for the hash table block, clocked on clk_i.
// ----------------------------------------------------------------------------
`ifndef HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH
`define HASH_TABLE_QUADRATIC_PROBE_ASSERT_SVH

`ifndef SYNTH
// Checked only while the block is out of reset.
`define HQP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hash table assertion failed");
// Checked at every edge, reset included.
`define HQP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("hash table assertion failed");
`else
`define HQP_ASSERT(lbl, prop)
`define HQP_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ----- rtl/hqp_pkg.sv -----
// ----------------------------------------------------------------------------
// Hash table package
// Sizes, codes and interface structs shared by the hash table modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hqp_pkg;

  localparam int TABLE_SIZE = 7;
  localparam int SLOT_W     = $clog2(TABLE_SIZE);
  localparam int REQ_W      = 2;
  localparam int STAT_W     = 3;
  localparam int KEY_W      = 31;
  localparam int VAL_W      = 32;

  // The key is reduced modulo the table size one hex digit per cycle.
  localparam int DIGIT_W    = 4;
  localparam int MOD_DIGITS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
  localparam int KEY_PAD_W  = MOD_DIGITS * DIGIT_W;
  localparam int DCNT_W     = $clog2(MOD_DIGITS);
  localparam int RED_W      = SLOT_W + DIGIT_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2
  } req_e;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_FULL      = 3'd1,
    ST_DELETED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FOUND     = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_HASH,
    S_PROBE,
    S_REPLY
  } state_e;

  typedef struct packed {
    logic              ins;
    logic              del;
    logic [SLOT_W-1:0] idx;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
  } slot_wr_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_rd_t;

endpackage

// ----- rtl/hqp_mod_unit.sv -----
// ----------------------------------------------------------------------------
// Hash table home slot unit
// Reduces a key modulo the table size, one hex digit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hqp_mod_unit import hqp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [KEY_W-1:0]  key_i,
  output logic              done_o,
  output logic [SLOT_W-1:0] rem_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [DCNT_W-1:0]    cnt_q, cnt_d;
  logic [KEY_PAD_W-1:0] sh_q, sh_d;
  logic [SLOT_W-1:0]    rem_q, rem_d;
  logic [RED_W-1:0]     red;

  // The partial remainder times sixteen plus a digit stays below sixteen
  // times the table size, so four conditional subtractions bring it back.
  always_comb begin
    red = {rem_q, sh_q[KEY_PAD_W-1 -: DIGIT_W]};
    for (int k = DIGIT_W - 1; k >= 0; k--) begin
      if (red >= RED_W'(TABLE_SIZE << k)) begin
        red = red - RED_W'(TABLE_SIZE << k);
      end
    end
  end

  always_comb begin
    run_d  = run_q;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    rem_d  = rem_q;
    done_d = run_q && (cnt_q == '0);
    if (load_i) begin
      run_d  = 1'b1;
      cnt_d  = DCNT_W'(MOD_DIGITS - 1);
      sh_d   = KEY_PAD_W'(key_i);
      rem_d  = '0;
      done_d = 1'b0;
    end else if (run_q) begin
      sh_d  = sh_q << DIGIT_W;
      rem_d = red[SLOT_W-1:0];
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        run_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q  <= sh_d;
    rem_q <= rem_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ----- rtl/hqp_slot_store.sv -----
// ----------------------------------------------------------------------------
// Hash table slot store
// Per-slot valid bits, keys and values with one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hqp_slot_store import hqp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  slot_wr_t          wr_i,
  input  logic [SLOT_W-1:0] rd_idx_i,
  output slot_rd_t          rd_o
);

  logic [TABLE_SIZE-1:0] valid_q, valid_d;
  logic [KEY_W-1:0]      key_q [TABLE_SIZE];
  logic [VAL_W-1:0]      val_q [TABLE_SIZE];

  always_comb begin
    valid_d = valid_q;
    if (wr_i.ins) begin
      valid_d[wr_i.idx] = 1'b1;
    end else if (wr_i.del) begin
      valid_d[wr_i.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // A deleted slot keeps stale contents; its valid bit hides them.
  always_ff @(posedge clk_i) begin
    if (wr_i.ins) begin
      key_q[wr_i.idx] <= wr_i.key;
      val_q[wr_i.idx] <= wr_i.value;
    end
  end

  always_comb begin
    rd_o.vld   = valid_q[rd_idx_i];
    rd_o.key   = key_q[rd_idx_i];
    rd_o.value = val_q[rd_idx_i];
  end

endmodule

// ----- rtl/hqp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Hash table probe sequencer
// Walks the quadratic probe sequence one slot per cycle and decides each request.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hqp_ctrl import hqp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [VAL_W-1:0]  value_in_i,
  input  logic              mod_done_i,
  input  logic [SLOT_W-1:0] home_i,
  input  slot_rd_t          rd_i,
  output logic              busy_o,
  output logic [SLOT_W-1:0] rd_idx_o,
  output slot_wr_t          wr_o,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [VAL_W-1:0]  value_out_o
);

  state_e            state_q, state_d;
  logic [REQ_W-1:0]  req_q;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [SLOT_W-1:0] pos_q, step_q, idx_q;
  status_e           status_q;
  logic [VAL_W-1:0]  vout_q;

  logic              accept;
  logic              hit, first, last;
  logic              fin;
  status_e           fin_status;
  logic [VAL_W-1:0]  fin_value;
  slot_wr_t          wr_c;
  logic [SLOT_W:0]   psum, ssum;
  logic [SLOT_W-1:0] pos_nxt, step_nxt;

  assign accept = start_i && (state_q == S_IDLE);

  // Consecutive squares differ by the next odd number, so both the slot and
  // the increment advance with an add and one conditional subtract.
  always_comb begin
    psum     = (SLOT_W+1)'(pos_q) + (SLOT_W+1)'(step_q);
    ssum     = (SLOT_W+1)'(step_q) + (SLOT_W+1)'(2);
    pos_nxt  = (psum >= (SLOT_W+1)'(TABLE_SIZE)) ?
               SLOT_W'(psum - (SLOT_W+1)'(TABLE_SIZE)) : SLOT_W'(psum);
    step_nxt = (ssum >= (SLOT_W+1)'(TABLE_SIZE)) ?
               SLOT_W'(ssum - (SLOT_W+1)'(TABLE_SIZE)) : SLOT_W'(ssum);
  end

  // An empty home slot does not end a search or delete; an empty slot
  // further along the sequence does.
  always_comb begin
    hit        = rd_i.vld && (rd_i.key == key_q);
    first      = (idx_q == '0);
    last       = (idx_q == SLOT_W'(TABLE_SIZE - 1));
    fin        = 1'b0;
    fin_status = ST_NOT_FOUND;
    fin_value  = '0;
    wr_c.ins   = 1'b0;
    wr_c.del   = 1'b0;
    wr_c.idx   = pos_q;
    wr_c.key   = key_q;
    wr_c.value = val_q;
    case (req_e'(req_q))
      REQ_INSERT: begin
        if (!rd_i.vld) begin
          fin        = 1'b1;
          fin_status = ST_INSERTED;
          wr_c.ins   = 1'b1;
        end else if (last) begin
          fin        = 1'b1;
          fin_status = ST_FULL;
        end
      end
      REQ_DELETE: begin
        if (hit) begin
          fin        = 1'b1;
          fin_status = ST_DELETED;
          wr_c.del   = 1'b1;
        end else if ((!rd_i.vld && !first) || last) begin
          fin = 1'b1;
        end
      end
      REQ_SEARCH: begin
        if (hit) begin
          fin        = 1'b1;
          fin_status = ST_FOUND;
          fin_value  = rd_i.value;
        end else if ((!rd_i.vld && !first) || last) begin
          fin = 1'b1;
        end
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_HASH;
      S_HASH:  if (mod_done_i) state_d = S_PROBE;
      S_PROBE: if (fin) state_d = S_REPLY;
      S_REPLY: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    busy_o   = (state_q != S_IDLE);
    done_o   = (state_q == S_REPLY);
    rd_idx_o = pos_q;
    wr_o     = wr_c;
    if (state_q != S_PROBE) begin
      wr_o.ins = 1'b0;
      wr_o.del = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_type_i;
      key_q <= key_i;
      val_q <= value_in_i;
    end
    if ((state_q == S_HASH) && mod_done_i) begin
      pos_q  <= home_i;
      step_q <= SLOT_W'(1);
      idx_q  <= '0;
    end else if (state_q == S_PROBE) begin
      if (fin) begin
        status_q <= fin_status;
        vout_q   <= fin_value;
      end else begin
        pos_q  <= pos_nxt;
        step_q <= step_nxt;
        idx_q  <= idx_q + 1'b1;
      end
    end
  end

  assign status_o    = status_q;
  assign value_out_o = vout_q;

endmodule

// ----- rtl/hash_table_quadratic_probe.sv -----
// ----------------------------------------------------------------------------
// Open-addressing hash table with quadratic probing
// Requests are insert, delete or search on a table of TABLE_SIZE slots.
// A request transaction is taken at a rising edge where start is high and
// busy is low; req_type_i, key_i and value_in_i are sampled there.
// busy stays high until the reply has been shown.
// Every request gives one reply: done_o is high for exactly one cycle with
// status_o and value_out_o valid in that cycle. The receiver cannot stall.
// After the accepting edge the key is reduced modulo the table size one hex
// digit at a time, the home slot is handed to the sequencer, the sequencer
// probes one slot per cycle, 1 to TABLE_SIZE slots in all, and the reply is
// shown. The next request is taken in the cycle after done_o.
// Reset empties every slot through the valid bits at once; no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hash_table_quadratic_probe_assert.svh"

module hash_table_quadratic_probe import hqp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [KEY_W-1:0]  key_i,
  input  logic [VAL_W-1:0]  value_in_i,
  output logic              busy,
  output logic              done_o,
  output logic [STAT_W-1:0] status_o,
  output logic [VAL_W-1:0]  value_out_o
);

  logic              mod_done;
  logic [SLOT_W-1:0] home;
  logic [SLOT_W-1:0] rd_idx;
  slot_rd_t          rd;
  slot_wr_t          wr;

  hqp_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (start && !busy),
    .key_i  (key_i),
    .done_o (mod_done),
    .rem_o  (home)
  );

  hqp_slot_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (wr),
    .rd_idx_i (rd_idx),
    .rd_o     (rd)
  );

  hqp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_in_i  (value_in_i),
    .mod_done_i  (mod_done),
    .home_i      (home),
    .rd_i        (rd),
    .busy_o      (busy),
    .rd_idx_o    (rd_idx),
    .wr_o        (wr),
    .done_o      (done_o),
    .status_o    (status_o),
    .value_out_o (value_out_o)
  );

  `HQP_ASSERT_ALWAYS(a_done_while_busy, done_o |-> busy)
  `HQP_ASSERT(a_accept_sets_busy, (start && !busy) |=> busy)
  `HQP_ASSERT(a_busy_ends_on_reply, $fell(busy) |-> $past(done_o))
  `HQP_ASSERT(a_value_only_found, (done_o && (value_out_o != '0)) |-> (status_o == ST_FOUND))

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quadratic-probe hash table testbench
// Sends insert, delete, search and unused-code requests through the start/busy
// handshake and keeps a shadow of the slot table. Each request's reply is
// predicted when the request is accepted, and each done_o strobe is checked
// against the oldest prediction. Directed corner cases come first, then
// random phases built on crowded key pools so that collisions and full
// probe walks are frequent.
// ----------------------------------------------------------------------------

import hqp_pkg::*;

typedef struct packed {
  status_e          status;
  logic [VAL_W-1:0] value;
} reply_t;

class quad_probe_shadow;
  bit               used [TABLE_SIZE];
  logic [KEY_W-1:0] keys [TABLE_SIZE];
  logic [VAL_W-1:0] words[TABLE_SIZE];
  reply_t           expected_replies[$];
  int               mismatches;
  int               replies_seen;
  int               op_count[4];
  int               status_count[8];

  function new();
    foreach (used[s]) begin
      used[s]  = 1'b0;
      keys[s]  = '0;
      words[s] = '0;
    end
    mismatches   = 0;
    replies_seen = 0;
    foreach (op_count[i]) op_count[i] = 0;
    foreach (status_count[i]) status_count[i] = 0;
  endfunction

  // The home slot is always examined, but only an empty probed slot ends the walk.
  function int find_key(logic [KEY_W-1:0] key);
    int home;
    int slot;
    home = int'(key % TABLE_SIZE);
    if (used[home] && keys[home] == key) return home;
    for (int i = 1; i < TABLE_SIZE; i++) begin
      slot = (home + i * i) % TABLE_SIZE;
      if (used[slot] && keys[slot] == key) return slot;
      if (!used[slot]) return -1;
    end
    return -1;
  endfunction

  function void apply_request(logic [REQ_W-1:0] op, logic [KEY_W-1:0] key,
                              logic [VAL_W-1:0] value);
    reply_t r;
    int     home;
    int     slot;
    r.status = ST_NOT_FOUND;
    r.value  = '0;
    op_count[op]++;
    case (op)
      REQ_INSERT: begin
        home = int'(key % TABLE_SIZE);
        slot = -1;
        if (!used[home]) begin
          slot = home;
        end else begin
          for (int i = 1; i < TABLE_SIZE && slot < 0; i++) begin
            if (!used[(home + i * i) % TABLE_SIZE]) slot = (home + i * i) % TABLE_SIZE;
          end
        end
        if (slot >= 0) begin
          used[slot]  = 1'b1;
          keys[slot]  = key;
          words[slot] = value;
          r.status    = ST_INSERTED;
        end else begin
          r.status = ST_FULL;
        end
      end
      REQ_DELETE: begin
        slot = find_key(key);
        if (slot >= 0) begin
          used[slot]  = 1'b0;
          keys[slot]  = '0;
          words[slot] = '0;
          r.status    = ST_DELETED;
        end
      end
      REQ_SEARCH: begin
        slot = find_key(key);
        if (slot >= 0) begin
          r.status = ST_FOUND;
          r.value  = words[slot];
        end
      end
      default: ;
    endcase
    expected_replies.push_back(r);
  endfunction

  function void report(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch on reply %0d: %s expected %0h, got %0h", replies_seen, what,
               want, got);
  endfunction

  function void match_reply(logic [STAT_W-1:0] status, logic [VAL_W-1:0] value);
    reply_t want;
    replies_seen++;
    if (!$isunknown(status)) status_count[status]++;
    if (expected_replies.size() == 0) begin
      report("unrequested reply, status", '0, 32'(status));
      return;
    end
    want = expected_replies.pop_front();
    if (status !== want.status) report("status", 32'(want.status), 32'(status));
    if (value !== want.value) report("value_out", want.value, value);
  endfunction
endclass

module tb;

  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE = 12;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic [REQ_W-1:0]  req_type_i;
  logic [KEY_W-1:0]  key_i;
  logic [VAL_W-1:0]  value_in_i;
  logic              busy;
  logic              done_o;
  logic [STAT_W-1:0] status_o;
  logic [VAL_W-1:0]  value_out_o;

  quad_probe_shadow shadow;
  int               cycles = 0;
  bit               no_idle = 1'b0;

  hash_table_quadratic_probe uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .req_type_i  (req_type_i),
    .key_i       (key_i),
    .value_in_i  (value_in_i),
    .busy        (busy),
    .done_o      (done_o),
    .status_o    (status_o),
    .value_out_o (value_out_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // A reply at an edge belongs to an earlier request, so it is checked first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) shadow.match_reply(status_o, value_out_o);
      if (start && !busy) shadow.apply_request(req_type_i, key_i, value_in_i);
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("simulation failed");
      $finish;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Keys whose home slots sit in slots 0 to spread; a small spread makes probe walks collide often.
  function automatic logic [KEY_W-1:0] crowded_key(int spread);
    int unsigned mult;
    mult = $urandom_range(0, (32'h7fffffff - TABLE_SIZE) / TABLE_SIZE);
    return KEY_W'(mult * TABLE_SIZE + $urandom_range(0, spread));
  endfunction

  task automatic send_request(input logic [REQ_W-1:0] op, input logic [KEY_W-1:0] key,
                              input logic [VAL_W-1:0] value);
    int gap;
    gap = no_idle ? 0 : pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start      <= 1'b1;
    req_type_i <= op;
    key_i      <= key;
    value_in_i <= value;
    do @(posedge clk_i); while (busy);
  endtask

  initial begin
    logic [KEY_W-1:0] pool[POOL_SIZE];
    int               ins_pct[4];
    int               del_pct[4];
    logic [REQ_W-1:0] op;
    logic [KEY_W-1:0] key;
    int               r;

    ins_pct = '{60, 35, 25, 20};
    del_pct = '{10, 25, 20, 45};
    shadow     = new();
    rst_ni     = 1'b0;
    start      = 1'b0;
    req_type_i = '0;
    key_i      = '0;
    value_in_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Lookups on an empty table end at the first empty slot after the home slot.
    send_request(REQ_SEARCH, '0, 32'hffffffff);
    send_request(REQ_DELETE, 31'h7fffffff, '0);
    // Four keys sharing home slot 0 take slots 0, 1, 4 and 2. The fifth finds
    // every probed slot taken, so the table counts as full with slots free.
    send_request(REQ_INSERT, 31'd0, 32'h00000000);
    send_request(REQ_INSERT, 31'd7, 32'hffffffff);
    send_request(REQ_INSERT, 31'd14, 32'ha5a5a5a5);
    send_request(REQ_INSERT, 31'd21, 32'h5a5a5a5a);
    send_request(REQ_INSERT, 31'd28, 32'h00000001);
    send_request(REQ_SEARCH, 31'd28, '0);
    send_request(REQ_SEARCH, 31'd14, '0);
    // Duplicate key: the copy in the home slot shadows the older one.
    send_request(REQ_DELETE, 31'd0, '0);
    send_request(REQ_INSERT, 31'd7, 32'h12345678);
    send_request(REQ_SEARCH, 31'd7, '0);
    send_request(REQ_DELETE, 31'd7, '0);
    // The home slot is empty now, but the walk still reaches the older copy.
    send_request(REQ_SEARCH, 31'd7, '0);
    send_request(REQ_DELETE, 31'd7, '0);
    // An empty probed slot ends the walk before the stored key is reached.
    send_request(REQ_SEARCH, 31'd14, '0);
    send_request(REQ_UNUSED, 31'd21, 32'hffffffff);
    send_request(REQ_SEARCH, 31'd21, '0);
    send_request(REQ_INSERT, 31'h7fffffff, 32'hffffffff);
    send_request(REQ_SEARCH, 31'h7fffffff, '0);
    send_request(REQ_DELETE, 31'h7fffffff, '0);

    // Random phases move from filling the table to draining it.
    for (int ph = 0; ph < 4; ph++) begin
      for (int j = 0; j < POOL_SIZE; j++) pool[j] = crowded_key(j < 8 ? 2 : TABLE_SIZE - 1);
      for (int n = 0; n < 200; n++) begin
        no_idle = (n < 40);
        r = $urandom_range(0, 99);
        if (r < ins_pct[ph]) op = REQ_INSERT;
        else if (r < ins_pct[ph] + del_pct[ph]) op = REQ_DELETE;
        else if (r < 96) op = REQ_SEARCH;
        else op = REQ_UNUSED;
        if ($urandom_range(0, 99) < 12) key = KEY_W'($urandom);
        else key = pool[$urandom_range(0, POOL_SIZE - 1)];
        send_request(op, key, $urandom);
      end
    end
    start <= 1'b0;

    while (shadow.expected_replies.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);

    $display("requests: %0d insert, %0d delete, %0d search, %0d with the unused code",
             shadow.op_count[REQ_INSERT], shadow.op_count[REQ_DELETE],
             shadow.op_count[REQ_SEARCH], shadow.op_count[REQ_UNUSED]);
    $display("replies: %0d inserted, %0d full, %0d deleted, %0d not found, %0d found",
             shadow.status_count[ST_INSERTED], shadow.status_count[ST_FULL],
             shadow.status_count[ST_DELETED], shadow.status_count[ST_NOT_FOUND],
             shadow.status_count[ST_FOUND]);
    if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d replies missing", shadow.mismatches,
               shadow.expected_replies.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/hqp_pkg.sv
rtl/hqp_mod_unit.sv
rtl/hqp_slot_store.sv
rtl/hqp_ctrl.sv
rtl/hash_table_quadratic_probe.sv
tb/sv/tb.sv
